// ===== design/pmm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmm_pkg: shared types and constants of the paged memory manager
// Request codes, status codes, memory geometry and the request/response
// payload structs.
// ----------------------------------------------------------------------------
package pmm_pkg;
   localparam int NUM_PAGES  = 64;
   localparam int PAGE_BYTES = 256;
   localparam int MEM_BYTES  = NUM_PAGES * PAGE_BYTES;
   localparam int ADDR_W     = $clog2(MEM_BYTES);
   localparam int PAGE_W     = $clog2(NUM_PAGES);
   localparam int OFF_W      = $clog2(PAGE_BYTES);

   typedef enum logic [1:0] {
      REQ_NEW   = 2'd0,
      REQ_KILL  = 2'd1,
      REQ_STORE = 2'd2,
      REQ_LOAD  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_TABLE = 2'd1,
      ST_NO_DATA  = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  proc_id;
      logic [6:0]  pages_wanted;
      logic [13:0] vaddr;
      logic [7:0]  store_data;
   } req_type_s_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  load_data;
      logic [13:0] paddr;
   } rsp_type_s_type;
endpackage

// ===== design/pmm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmm_if: valid/ready channel interfaces
// One interface for request beats and one for response beats.
// ----------------------------------------------------------------------------
interface pmm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [7:0]  proc_id;
   logic [6:0]  pages_wanted;
   logic [13:0] vaddr;
   logic [7:0]  store_data;
   modport source (output valid, req_type, proc_id, pages_wanted, vaddr, store_data,
                   input ready);
   modport sink   (input valid, req_type, proc_id, pages_wanted, vaddr, store_data,
                   output ready);
endinterface

interface pmm_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  load_data;
   logic [13:0] paddr;
   modport source (output valid, status, load_data, paddr, input ready);
   modport sink   (input valid, status, load_data, paddr, output ready);
endinterface

// ===== design/pmm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmm_front: request intake and queue
// Takes request beats into a two-entry queue that feeds the executor.
// ----------------------------------------------------------------------------
module pmm_front (
   input  logic                     clock,
   input  logic                     reset,
   pmm_req_if.sink                  req,
   output logic                     q_valid,
   output pmm_pkg::req_type_s_type  q_item,
   input  logic                     q_pop
);
   pmm_pkg::req_type_s_type mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign req.ready = (cnt_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ (q_pop && q_valid);
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop && q_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= '{req_type: req.req_type, proc_id: req.proc_id,
                            pages_wanted: req.pages_wanted, vaddr: req.vaddr,
                            store_data: req.store_data};
      end
   end
endmodule

// ===== design/pmm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmm_back: request executor
// Sequencer over the byte memory: clear pass, first-fit scans, kill walk,
// translation and byte access. One memory access per cycle, registered read.
// ----------------------------------------------------------------------------
module pmm_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  pmm_pkg::req_type_s_type  q_item,
   output logic                     q_pop,
   pmm_rsp_if.source                rsp
);
   localparam int AW = pmm_pkg::ADDR_W;
   localparam int PW = pmm_pkg::PAGE_W;
   localparam int OW = pmm_pkg::OFF_W;

   typedef enum logic [13:0] {
      S_CLEAR  = 14'b00000000000001,
      S_IDLE   = 14'b00000000000010,
      S_SCAN   = 14'b00000000000100,  // read map byte at scan_ff
      S_SCHK   = 14'b00000000001000,  // check read data
      S_SLOT   = 14'b00000000010000,  // read slot
      S_TBL    = 14'b00000000100000,  // read table entry
      S_XLAT   = 14'b00000001000000,  // read/write data byte
      S_LDW    = 14'b00000010000000,
      S_KRD    = 14'b00000100000000,  // read entry k
      S_KCHK   = 14'b00001000000000,
      S_KFREE  = 14'b00010000000000,
      S_SLOTW  = 14'b00100000000000,
      S_OUT    = 14'b01000000000000,
      S_SLOTWT = 14'b10000000000000
   } state_type;

   logic [7:0] mem [pmm_pkg::MEM_BYTES];
   logic [7:0] rd_ff;
   logic          we, re;
   logic [AW-1:0] addr;
   logic [7:0]    wdata;

   state_type st_ff, st_in;
   pmm_pkg::req_type_s_type it_ff;
   logic [AW-1:0] clr_ff, clr_in;
   logic [PW:0]   scan_ff, scan_in;
   logic [6:0]    x_ff, x_in;
   logic          tbl_phase_ff, tbl_phase_in;   // 1 while taking table page
   logic [7:0]    tbl_ff, tbl_in;
   logic [7:0]    pg_ff, pg_in;
   logic [PW:0]   k_ff, k_in;
   logic [1:0]    status_ff, status_in;
   logic [7:0]    ld_ff, ld_in;
   logic [AW-1:0] pa_ff, pa_in;
   logic          ov_ff, ov_in;
   logic          take;

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      if (re) rd_ff <= mem[addr];
   end

   assign rsp.valid     = ov_ff;
   assign rsp.status    = status_ff;
   assign rsp.load_data = ld_ff;
   assign rsp.paddr     = pa_ff;
   assign take          = rsp.ready && ov_ff;

   always_comb begin
      st_in = st_ff; clr_in = clr_ff; scan_in = scan_ff; x_in = x_ff;
      tbl_phase_in = tbl_phase_ff; tbl_in = tbl_ff; pg_in = pg_ff; k_in = k_ff;
      status_in = status_ff; ld_in = ld_ff; pa_in = pa_ff;
      ov_in = ov_ff && !take;
      we = 1'b0; re = 1'b0; addr = '0; wdata = '0; q_pop = 1'b0;
      unique case (st_ff)
         S_CLEAR: begin
            we = 1'b1; addr = clr_ff;
            wdata = (clr_ff == '0) ? 8'd1 : 8'd0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(pmm_pkg::MEM_BYTES - 1)) st_in = S_IDLE;
         end
         S_IDLE: begin
            // result registers double as the response beat; start only once it has left
            if (q_valid && (!ov_ff || take)) begin
               q_pop = 1'b1; status_in = pmm_pkg::ST_OK; ld_in = '0; pa_in = '0;
               unique case (pmm_pkg::req_kind_type'(q_item.req_type))
                  pmm_pkg::REQ_NEW: begin
                     scan_in = '0; tbl_phase_in = 1'b1; x_in = '0; st_in = S_SCAN;
                  end
                  default: st_in = S_SLOT;
               endcase
            end
         end
         S_SCAN: begin
            if (scan_ff == (PW+1)'(pmm_pkg::NUM_PAGES)) begin
               status_in = tbl_phase_ff ? pmm_pkg::ST_NO_TABLE : pmm_pkg::ST_NO_DATA;
               st_in = S_OUT;
            end else begin
               re = 1'b1; addr = AW'(scan_ff); st_in = S_SCHK;
            end
         end
         S_SCHK: begin
            if (rd_ff == 8'd0) begin
               we = 1'b1; addr = AW'(scan_ff); wdata = 8'd1;
               if (tbl_phase_ff) begin
                  tbl_in = 8'(scan_ff); tbl_phase_in = 1'b0; st_in = S_SLOTWT;
               end else begin
                  pg_in = 8'(scan_ff); st_in = S_SLOTW;
               end
            end else begin
               scan_in = scan_ff + 1'b1; st_in = S_SCAN;
            end
         end
         S_SLOTWT: begin
            we = 1'b1; addr = AW'(pmm_pkg::NUM_PAGES + int'(it_ff.proc_id));
            wdata = tbl_ff;
            st_in = S_SLOTW; pg_in = '0;
            if (it_ff.pages_wanted == 7'd0) st_in = S_OUT;
            else begin scan_in = '0; st_in = S_SCAN; end
         end
         S_SLOTW: begin
            // write data-page entry x, then continue
            we = 1'b1; addr = AW'({tbl_ff, OW'(0)} + AW'(x_ff)); wdata = pg_ff;
            x_in = x_ff + 1'b1; scan_in = '0;
            st_in = (x_ff + 1'b1 == it_ff.pages_wanted) ? S_OUT : S_SCAN;
         end
         S_SLOT: begin
            re = 1'b1; addr = AW'(pmm_pkg::NUM_PAGES + int'(it_ff.proc_id));
            k_in = '0;
            st_in = (it_ff.req_type == pmm_pkg::REQ_KILL) ? S_KRD : S_TBL;
         end
         S_TBL: begin
            tbl_in = rd_ff; re = 1'b1;
            addr = AW'({rd_ff, OW'(0)} + AW'(it_ff.vaddr[AW-1:OW]));
            st_in = S_XLAT;
         end
         S_XLAT: begin
            addr = AW'({rd_ff, it_ff.vaddr[OW-1:0]});
            pa_in = addr;
            if (it_ff.req_type == pmm_pkg::REQ_STORE) begin
               we = 1'b1; wdata = it_ff.store_data; st_in = S_OUT;
            end else begin
               re = 1'b1; st_in = S_LDW;
            end
         end
         S_LDW: begin
            ld_in = rd_ff; st_in = S_OUT;
         end
         S_KRD: begin
            if (k_ff == '0) tbl_in = rd_ff;
            if (k_ff == (PW+1)'(pmm_pkg::NUM_PAGES)) begin
               we = 1'b1; addr = AW'(tbl_ff); wdata = '0; st_in = S_OUT;
            end else begin
               re = 1'b1;
               addr = AW'({((k_ff == '0) ? rd_ff : tbl_ff), OW'(0)} + AW'(k_ff));
               st_in = S_KCHK;
            end
         end
         S_KCHK: begin
            if (rd_ff != 8'd0) begin
               we = 1'b1; addr = AW'(rd_ff); wdata = '0;
            end
            k_in = k_ff + 1'b1; st_in = S_KFREE;
         end
         S_KFREE: st_in = S_KRD;
         S_OUT: begin
            if (!ov_ff || take) begin
               ov_in = 1'b1; st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLEAR; clr_ff <= '0; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; clr_ff <= clr_in; ov_ff <= ov_in;
      end
      scan_ff <= scan_in; x_ff <= x_in; tbl_phase_ff <= tbl_phase_in;
      tbl_ff <= tbl_in; pg_ff <= pg_in; k_ff <= k_in;
      status_ff <= status_in; ld_ff <= ld_in; pa_ff <= pa_in;
      if (q_pop) it_ff <= q_item;
   end
endmodule

// ===== design/paged_memory_manager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paged_memory_manager: single-level page table manager with free-page map
// New process: pages are taken by a first-fit scan of the free-page map,
// one map byte at a time.
// One request runs at a time; the next starts once the response beat is gone.
// Reset: a clearing pass zeroes all 16384 bytes, byte 0 set to 1;
// no request is executed until it ends.
// ----------------------------------------------------------------------------
module paged_memory_manager (
   input logic        clock,
   input logic        reset,
   pmm_req_if.sink    req,
   pmm_rsp_if.source  rsp
);
   logic                    q_valid, q_pop;
   pmm_pkg::req_type_s_type q_item;

   pmm_front u_front (.clock, .reset, .req, .q_valid, .q_item, .q_pop);
   pmm_back  u_back  (.clock, .reset, .q_valid, .q_item, .q_pop, .rsp);

   a_stat: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.status != 2'd3) else $error("bad status");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid) else $error("response lost");
   a_keep: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> $stable({rsp.status, rsp.load_data, rsp.paddr}))
      else $error("response changed while waiting");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop on empty queue");
endmodule
